[hw/rtl/ucf_pkg.sv]
// Shared types, constants and the code point fold function for the UTF-8 fold block.
// Used by every module under hw/rtl; has no dependencies of its own.
`default_nettype none

package ucf_pkg;

  localparam int CODE_W      = 21;
  localparam int CHAR_W      = 7;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int GLYPH_COUNT = 25;

  // Continuation counts taken from the lead byte.
  localparam logic [1:0] FOLLOW_NONE  = 2'd0;
  localparam logic [1:0] FOLLOW_ONE   = 2'd1;
  localparam logic [1:0] FOLLOW_TWO   = 2'd2;
  localparam logic [1:0] FOLLOW_THREE = 2'd3;

  localparam logic [15:0] GLYPH_CODE [GLYPH_COUNT] = '{
    16'h0410, 16'h0412, 16'h0421, 16'h0420, 16'h041E, 16'h0415, 16'h0425,
    16'h041C, 16'h0422, 16'h041A, 16'h041D, 16'h0423, 16'h0417,
    16'h0430, 16'h0441, 16'h0435, 16'h043E, 16'h0440, 16'h0445, 16'h043C,
    16'h0442, 16'h043A, 16'h043D, 16'h0443, 16'h0437
  };

  localparam logic [CHAR_W-1:0] GLYPH_ASCII [GLYPH_COUNT] = '{
    7'h41, 7'h42, 7'h43, 7'h50, 7'h4F, 7'h45, 7'h58,
    7'h4D, 7'h54, 7'h4B, 7'h48, 7'h59, 7'h33,
    7'h41, 7'h43, 7'h45, 7'h4F, 7'h50, 7'h58, 7'h4D,
    7'h54, 7'h4B, 7'h48, 7'h59, 7'h33
  };

  // One decoded transaction handed from the front to the back.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              done;
    logic              last;
  } ucf_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ucf_qstat_t;

  typedef struct packed {
    logic              keep;
    logic [CHAR_W-1:0] ch;
  } ucf_fold_t;

  // Maps a complete code point to its ASCII form; keep is low when it is dropped.
  function automatic ucf_fold_t fold_code(input logic [CODE_W-1:0] cp);
    ucf_fold_t res;
    res.keep = 1'b0;
    res.ch   = '0;
    if (cp[CODE_W-1:CHAR_W] == '0) begin
      res.keep = 1'b1;
      if (cp[CHAR_W-1:0] >= 7'h61 && cp[CHAR_W-1:0] <= 7'h7A) begin
        res.ch = cp[CHAR_W-1:0] - 7'h20;
      end else begin
        res.ch = cp[CHAR_W-1:0];
      end
    end else begin
      for (int k = 0; k < GLYPH_COUNT; k++) begin
        if (cp == {5'd0, GLYPH_CODE[k]}) begin
          res.keep = 1'b1;
          res.ch   = GLYPH_ASCII[k];
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ucf_front.sv]
// Front end: accepts bytes, tracks the UTF-8 sequence state and emits decoded entries.
// Depends on ucf_pkg.
`default_nettype none

module ucf_front
  import ucf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       name_end,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire ucf_qstat_t qstat,
  output logic            push,
  output ucf_entry_t      push_data
);

  logic [CODE_W-1:0] code_accum, code_accum_next;
  logic [1:0]        bytes_left, bytes_left_next;
  logic              done;
  logic              take;

  assign in_stall = qstat.full;
  assign take     = in_valid && !qstat.full;

  always_comb begin
    code_accum_next = code_accum;
    bytes_left_next = bytes_left;
    done            = 1'b0;
    if (bytes_left == FOLLOW_NONE) begin
      if (!in_byte[7]) begin
        code_accum_next = {13'd0, in_byte};
        done            = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        code_accum_next = {16'd0, in_byte[4:0]};
        bytes_left_next = FOLLOW_ONE;
      end else if (in_byte[7:4] == 4'b1110) begin
        code_accum_next = {17'd0, in_byte[3:0]};
        bytes_left_next = FOLLOW_TWO;
      end else if (in_byte[7:3] == 5'b11110) begin
        code_accum_next = {18'd0, in_byte[2:0]};
        bytes_left_next = FOLLOW_THREE;
      end
    end else begin
      // Any byte is taken as a continuation while one is expected.
      code_accum_next = {code_accum[CODE_W-7:0], in_byte[5:0]};
      bytes_left_next = bytes_left - 2'd1;
      done            = (bytes_left == FOLLOW_ONE);
    end
  end

  assign push           = take && (done || name_end);
  assign push_data.code = code_accum_next;
  assign push_data.done = done;
  assign push_data.last = name_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_accum <= '0;
      bytes_left <= FOLLOW_NONE;
    end else if (take) begin
      if (name_end) begin
        code_accum <= '0;
        bytes_left <= FOLLOW_NONE;
      end else begin
        code_accum <= code_accum_next;
        bytes_left <= bytes_left_next;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ucf_queue.sv]
// Small FIFO of decoded entries between the front and the back end.
// Depends on ucf_pkg.
`default_nettype none

module ucf_queue
  import ucf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire ucf_entry_t push_data,
  input  wire logic       pop,
  output ucf_entry_t      pop_data,
  output ucf_qstat_t      qstat
);

  ucf_entry_t        slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_data    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ucf_back.sv]
// Back end: folds decoded code points to ASCII and holds the result register.
// Depends on ucf_pkg.
`default_nettype none

module ucf_back
  import ucf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ucf_qstat_t  qstat,
  input  wire ucf_entry_t  pop_data,
  output logic             pop,
  output logic [CHAR_W-1:0] out_char,
  output logic             char_valid,
  output logic             end_of_output,
  output logic             out_valid,
  input  wire logic        out_stall
);

  ucf_fold_t fold;
  logic      kept;
  logic      room;

  assign fold = fold_code(pop_data.code);
  assign kept = pop_data.done && fold.keep;
  // The output register can take a new transaction when it is empty or draining.
  assign room = !out_valid || !out_stall;
  assign pop  = !qstat.empty && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= pop && (kept || pop_data.last);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (kept || pop_data.last)) begin
      out_char      <= kept ? fold.ch : '0;
      char_valid    <= kept;
      end_of_output <= pop_data.last;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/utf8_confusable_fold_top.sv]
// Top level of the UTF-8 homoglyph fold block: front decoder, entry queue, fold back end.
// Depends on ucf_pkg, ucf_front, ucf_queue and ucf_back.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+--------------------------------------
//   input   | in_valid / in_stall  | in_byte, name_end
//   output  | out_valid / out_stall| out_char, char_valid, end_of_output
//
// One byte is accepted every cycle while the four-entry queue has room.
// A result is held first in a queue slot, then in the output register. Synchronous
// reset clears the sequence state, the queue and the output valid flag. A stall on the
// output fills the queue, and in_stall rises once all four entries are taken.
`default_nettype none

module utf8_confusable_fold_top
  import ucf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        in_byte,
  input  wire logic              name_end,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   char_valid,
  output logic                   end_of_output,
  output logic                   out_valid,
  input  wire logic              out_stall
);

  ucf_qstat_t qstat;
  ucf_entry_t push_data, pop_data;
  logic       push, pop;

  ucf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .name_end  (name_end),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  ucf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  ucf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .qstat         (qstat),
    .pop_data      (pop_data),
    .pop           (pop),
    .out_char      (out_char),
    .char_valid    (char_valid),
    .end_of_output (end_of_output),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

endmodule

`default_nettype wire

[tb/utf8_confusable_fold_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for utf8_confusable_fold_top: UTF-8 names in, folded ASCII out.
// Depends on ucf_pkg for the port widths and the continuation count names.
module utf8_confusable_fold_top_tb;
  import ucf_pkg::*;

  localparam int HOMO_COUNT = 25;

  // Cyrillic look-alikes and the ASCII character each one folds to.
  localparam logic [15:0] HOMO_CODE [HOMO_COUNT] = '{
    16'h0410, 16'h0412, 16'h0421, 16'h0420, 16'h041E, 16'h0415, 16'h0425,
    16'h041C, 16'h0422, 16'h041A, 16'h041D, 16'h0423, 16'h0417,
    16'h0430, 16'h0441, 16'h0435, 16'h043E, 16'h0440, 16'h0445, 16'h043C,
    16'h0442, 16'h043A, 16'h043D, 16'h0443, 16'h0437
  };
  localparam logic [6:0] HOMO_CHAR [HOMO_COUNT] = '{
    7'h41, 7'h42, 7'h43, 7'h50, 7'h4F, 7'h45, 7'h58,
    7'h4D, 7'h54, 7'h4B, 7'h48, 7'h59, 7'h33,
    7'h41, 7'h43, 7'h45, 7'h4F, 7'h50, 7'h58, 7'h4D,
    7'h54, 7'h4B, 7'h48, 7'h59, 7'h33
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } name_byte_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              has_char;
    logic              is_last;
  } folded_char_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [7:0]        in_byte = '0;
  logic              name_end = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CHAR_W-1:0] out_char;
  logic              char_valid;
  logic              end_of_output;
  logic              out_valid;
  logic              out_stall = 1'b0;

  name_byte_t   name_bytes[$];
  logic [7:0]   name_buf[$];
  folded_char_t expected_chars[$];

  logic [20:0]  seq_code = '0;
  logic [1:0]   seq_left = FOLLOW_NONE;
  logic         in_taken = 1'b0;
  int           in_gap = 0;
  int           stall_left = 0;
  int unsigned  cycle_count = 0;
  int           mismatches = 0;

  utf8_confusable_fold_top dut (
    .clk(clk), .rst(rst), .in_byte(in_byte), .name_end(name_end), .in_valid(in_valid),
    .in_stall(in_stall), .out_char(out_char), .char_valid(char_valid),
    .end_of_output(end_of_output), .out_valid(out_valid), .out_stall(out_stall)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic logic fold_lookup(input logic [20:0] cp, output logic [6:0] ch);
    ch = '0;
    if (cp < 21'd128) begin
      ch = (cp[6:0] >= 7'h61 && cp[6:0] <= 7'h7A) ? cp[6:0] - 7'h20 : cp[6:0];
      return 1'b1;
    end
    for (int k = 0; k < HOMO_COUNT; k++) begin
      if (cp == {5'd0, HOMO_CODE[k]}) begin
        ch = HOMO_CHAR[k];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advances the decoder state by one byte and queues the result it causes, if any.
  task automatic fold_byte(input logic [7:0] b, input logic last);
    logic       done;
    logic       keep;
    logic [6:0] ch;
    done = 1'b0;
    keep = 1'b0;
    ch = '0;
    if (seq_left == FOLLOW_NONE) begin
      if (b[7] == 1'b0) begin
        seq_code = {13'd0, b};
        done = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        seq_code = {16'd0, b[4:0]};
        seq_left = FOLLOW_ONE;
      end else if (b[7:4] == 4'b1110) begin
        seq_code = {17'd0, b[3:0]};
        seq_left = FOLLOW_TWO;
      end else if (b[7:3] == 5'b11110) begin
        seq_code = {18'd0, b[2:0]};
        seq_left = FOLLOW_THREE;
      end
    end else begin
      // The top bits of a continuation byte are ignored.
      seq_code = {seq_code[14:0], b[5:0]};
      seq_left = seq_left - 2'd1;
      done = (seq_left == FOLLOW_NONE);
    end
    if (done) keep = fold_lookup(seq_code, ch);
    if (last) begin
      seq_code = '0;
      seq_left = FOLLOW_NONE;
    end
    if (keep || last) begin
      expected_chars.insert(expected_chars.size(),
                            '{ch: keep ? ch : 7'd0, has_char: keep, is_last: last});
    end
  endtask

  // Mostly no gap, sometimes a short one, rarely a long one; none in calm stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((cycle_count % 600) < 120) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic put(input logic [7:0] b);
    name_buf.insert(name_buf.size(), b);
  endtask

  task automatic put_cont(input logic [5:0] bits, input bit noisy);
    logic [1:0] top;
    top = (noisy && $urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
    put({top, bits});
  endtask

  task automatic encode(input logic [20:0] cp, input int n, input bit noisy);
    case (n)
      1: put({1'b0, cp[6:0]});
      2: begin
        put({3'b110, cp[10:6]});
        put_cont(cp[5:0], noisy);
      end
      3: begin
        put({4'b1110, cp[15:12]});
        put_cont(cp[11:6], noisy);
        put_cont(cp[5:0], noisy);
      end
      default: begin
        put({5'b11110, cp[20:18]});
        put_cont(cp[17:12], noisy);
        put_cont(cp[11:6], noisy);
        put_cont(cp[5:0], noisy);
      end
    endcase
  endtask

  task automatic close_name();
    for (int i = 0; i < name_buf.size(); i++) begin
      name_bytes.insert(name_bytes.size(),
                        '{data: name_buf[i], last: (i == name_buf.size() - 1)});
    end
    name_buf.delete();
  endtask

  task automatic add_random_name();
    int          cps;
    int          r;
    int          n;
    int          conts;
    logic [20:0] cp;
    cps = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
    for (int k = 0; k < cps; k++) begin
      r = $urandom_range(0, 99);
      n = $urandom_range(2, 4);
      if (r < 35) begin
        put(8'($urandom_range(0, 127)));
      end else if (r < 50) begin
        encode({5'd0, HOMO_CODE[$urandom_range(0, HOMO_COUNT - 1)]}, 2, r >= 47);
      end else if (r < 58) begin
        // Overlong forms of ASCII still fold.
        encode(21'($urandom_range(0, 127)), n, 1'b0);
      end else if (r < 70) begin
        cp = 21'($urandom);
        if (n == 2) cp[20:11] = '0;
        if (n == 3) cp[20:16] = '0;
        encode(cp, n, $urandom_range(0, 4) == 0);
      end else if (r < 78) begin
        encode({5'd0, HOMO_CODE[$urandom_range(0, HOMO_COUNT - 1)]}, $urandom_range(3, 4), 1'b0);
      end else if (r < 86) begin
        put($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                 : 8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
        put(8'($urandom_range(0, 255)));
      end
    end
    // Now and then the name stops in the middle of a sequence.
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(2, 4);
      conts = $urandom_range(0, n - 2);
      case (n)
        2: put({3'b110, 5'($urandom)});
        3: put({4'b1110, 4'($urandom)});
        default: put({5'b11110, 3'($urandom)});
      endcase
      for (int j = 0; j < conts; j++) put({2'b10, 6'($urandom)});
    end
    close_name();
  endtask

  // Input driver.
  always @(negedge clk) begin
    name_byte_t nb;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // Hold the stalled transaction.
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (name_bytes.size() > 0) begin
      nb = name_bytes.pop_front();
      in_byte <= nb.data;
      name_end <= nb.last;
      in_valid <= 1'b1;
      in_gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Output back-pressure.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // Monitor: checks each output transaction, then predicts from the accepted input.
  always @(posedge clk) begin
    folded_char_t want;
    cycle_count <= cycle_count + 1;
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected result", out_char, 0);
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) report_mismatch("out_char", out_char, want.ch);
          if (char_valid !== want.has_char)
            report_mismatch("char_valid", char_valid, want.has_char);
          if (end_of_output !== want.is_last)
            report_mismatch("end_of_output", end_of_output, want.is_last);
        end
      end
      if (in_valid && !in_stall) fold_byte(in_byte, name_end);
    end
  end

  initial begin
    // ASCII codes at and just below the lower-case letter range, plus the smallest and largest ASCII codes.
    put(8'h61); put(8'h7A); put(8'h60); put(8'h00); put(8'h7F); close_name();
    // Two-byte homoglyphs.
    put(8'hD0); put(8'h90); put(8'hD1); put(8'h83); put(8'hD0); put(8'h97); close_name();
    // Overlong lower-case letter, then the largest four-byte code point.
    put(8'hC1); put(8'hA1); put(8'hF7); put(8'hBF); put(8'hBF); put(8'hBF); close_name();
    // Invalid leads, an unmapped code point, and an invalid lead as the last byte.
    put(8'h80); put(8'hF8); put(8'hC2); put(8'hA9); put(8'hFF); close_name();
    // Continuations are taken whatever their top bits are.
    put(8'hC0); put(8'h41); put(8'hD0); put(8'hD0); close_name();
    // Name cut off inside a sequence.
    put(8'hE2); put(8'h82); close_name();
    while (name_bytes.size() < 450) add_random_name();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (name_bytes.size() > 0 || in_valid) @(posedge clk);
    while (expected_chars.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
